/* hw/rtl/scce_pkg.sv */
// Shared constants, codes and beat types of the split counter chunk engine.
package scce_pkg;

   localparam int MAX_CHUNKS = 64;
   localparam int ADDR_W     = $clog2(MAX_CHUNKS);
   localparam int COUNT_W    = $clog2(MAX_CHUNKS + 1);
   localparam int SUM_W      = 32 + ADDR_W;
   localparam int RATE_W     = 9;
   localparam int PROD_W     = COUNT_W + RATE_W;

   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_ADD     = 3'd1;
   localparam logic [2:0] OP_SUB     = 3'd2;
   localparam logic [2:0] OP_GROW    = 3'd3;
   localparam logic [2:0] OP_SHRINK  = 3'd4;
   localparam logic [2:0] OP_BALANCE = 3'd5;
   localparam logic [2:0] OP_FETCH   = 3'd6;

   localparam logic [1:0] OUT_DONE    = 2'd0;
   localparam logic [1:0] OUT_REFUSED = 2'd1;
   localparam logic [1:0] OUT_RANGE   = 2'd2;

   localparam logic CSR_INIT_CHUNKS = 1'b0;
   localparam logic CSR_THRESHOLD   = 1'b1;

   typedef struct packed {
      logic [2:0]        op;
      logic              op_undefined;
      logic              second_is_next;
      logic [31:0]       amount;
      logic [ADDR_W-1:0] first_index;
      logic [ADDR_W-1:0] second_index;
      logic [RATE_W-1:0] grow_rate;
   } cmd_type;

   typedef struct packed {
      logic [31:0]        total;
      logic [1:0]         outcome;
      logic [COUNT_W-1:0] active_count;
      logic [15:0]        commits;
      logic [15:0]        aborts;
   } rsp_type;

endpackage

/* hw/rtl/split_counter_chunk_engine.sv */
// Top level of the split counter chunk engine: request queue, sequencer and response queue.
//
// One 32-bit counter value is kept spread over up to 64 chunks in a single-port-read,
// single-port-write memory with registered read data; a valid bit per chunk makes an
// unwritten or removed chunk read as zero, so reset and chunk-count changes need no
// clearing pass. Request beats are decoded into a two-entry command queue, and the
// sequencer works on one command at a time, pushing one response beat per request into a
// two-entry response queue, so a new request is taken while earlier responses wait. The
// memory port sets the time per command: read and sub first sum every active chunk,
// sub then reads and writes each chunk that it visits, and the other commands touch at
// most two chunks. At most 64 chunks are active.
module split_counter_chunk_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [2:0]                  req_op,
   input  logic [31:0]                 req_amount,
   input  logic [scce_pkg::ADDR_W-1:0] req_first_index,
   input  logic [scce_pkg::ADDR_W-1:0] req_second_index,
   input  logic [scce_pkg::RATE_W-1:0] req_grow_rate,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [31:0]                 rsp_total,
   output logic [1:0]                  rsp_outcome,
   output logic [scce_pkg::COUNT_W-1:0] rsp_active_count,
   output logic [15:0]                 rsp_commits,
   output logic [15:0]                 rsp_aborts,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [31:0]                 csr_data
);

   // Decoded commands travel from the front end to the sequencer through a short queue.
   scce_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;

   // Finished results wait in the response queue until the consumer pops them.
   scce_pkg::rsp_type rsp_new;
   scce_pkg::rsp_type rsp_head;
   logic              rsp_push;
   logic              rsp_full;

   scce_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_op           (req_op),
      .req_amount       (req_amount),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_grow_rate    (req_grow_rate),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   // The sequencer only starts a command when the response queue has room, so the beat
   // it pushes at the end can never be lost.
   scce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_new)
   );

   scce_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head      (rsp_head)
   );

   // The oldest waiting response beat drives the result ports.
   assign rsp_total        = rsp_head.total;
   assign rsp_outcome      = rsp_head.outcome;
   assign rsp_active_count = rsp_head.active_count;
   assign rsp_commits      = rsp_head.commits;
   assign rsp_aborts       = rsp_head.aborts;

endmodule

/* hw/rtl/scce_front.sv */
// Front end: accepts request beats, decodes them and queues them for the back end.
module scce_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [2:0]                 req_op,
   input  logic [31:0]                req_amount,
   input  logic [scce_pkg::ADDR_W-1:0] req_first_index,
   input  logic [scce_pkg::ADDR_W-1:0] req_second_index,
   input  logic [scce_pkg::RATE_W-1:0] req_grow_rate,
   output logic                       cmd_valid,
   output scce_pkg::cmd_type          cmd,
   input  logic                       cmd_pop
);

   scce_pkg::cmd_type q_ff [2];
   scce_pkg::cmd_type entry;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       accept;

   always_comb begin
      entry.op             = req_op;
      entry.op_undefined   = (req_op != scce_pkg::OP_READ) && (req_op != scce_pkg::OP_ADD) &&
                             (req_op != scce_pkg::OP_SUB) && (req_op != scce_pkg::OP_GROW) &&
                             (req_op != scce_pkg::OP_SHRINK) &&
                             (req_op != scce_pkg::OP_BALANCE) && (req_op != scce_pkg::OP_FETCH);
      entry.second_is_next = (req_second_index == req_first_index);
      entry.amount         = req_amount;
      entry.first_index    = req_first_index;
      entry.second_index   = req_second_index;
      entry.grow_rate      = req_grow_rate;
   end

   assign req_full  = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign accept    = req_push && !req_full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      fill_in   = fill_ff + {1'b0, accept} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* hw/rtl/scce_rsp_queue.sv */
// Two-entry result queue that holds finished response beats until they are popped.
module scce_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scce_pkg::rsp_type push_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output scce_pkg::rsp_type head
);

   scce_pkg::rsp_type q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       take;

   assign full  = (fill_ff == 2'd2);
   assign empty = (fill_ff == 2'd0);
   assign head  = q_ff[rd_ptr_ff];
   assign take  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ push;
         rd_ptr_ff <= rd_ptr_ff ^ take;
         fill_ff   <= fill_ff + {1'b0, push} - {1'b0, take};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/scce_back.sv */
// Back end: chunk memory, configuration registers and the sequencer that carries out commands.
module scce_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [31:0]                csr_data,
   input  logic                       cmd_valid,
   input  scce_pkg::cmd_type          cmd,
   output logic                       cmd_pop,
   input  logic                       rsp_full,
   output logic                       rsp_push,
   output scce_pkg::rsp_type          rsp_data
);

   localparam int CW = scce_pkg::COUNT_W;
   localparam int AW = scce_pkg::ADDR_W;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EXEC    = 4'd1;
   localparam logic [3:0] S_SUM     = 4'd2;
   localparam logic [3:0] S_WALK_RD = 4'd3;
   localparam logic [3:0] S_WALK_WR = 4'd4;
   localparam logic [3:0] S_ADD_WR  = 4'd5;
   localparam logic [3:0] S_SHR_RD2 = 4'd6;
   localparam logic [3:0] S_SHR_WR  = 4'd7;
   localparam logic [3:0] S_BAL_RD2 = 4'd8;
   localparam logic [3:0] S_BAL_WR1 = 4'd9;
   localparam logic [3:0] S_BAL_WR2 = 4'd10;
   localparam logic [3:0] S_DONE    = 4'd11;

   logic [31:0] mem [scce_pkg::MAX_CHUNKS];
   logic [scce_pkg::MAX_CHUNKS-1:0] valid_ff;
   logic [31:0] rdata_ff;
   logic        rvalid_ff;
   logic [31:0] rd;

   logic [3:0]                state_ff, state_in;
   scce_pkg::cmd_type         cmd_ff, cmd_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [scce_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                      pend_ff, pend_in;
   logic [31:0]               left_ff, left_in;
   logic [31:0]               tmp_ff, tmp_in;
   logic [AW-1:0]             j_ff, j_in;
   logic [1:0]                outcome_ff, outcome_in;
   logic [31:0]               total_ff, total_in;
   logic [15:0]               rc_ff, rc_in, ra_ff, ra_in;
   logic [15:0]               commit_ff, commit_in, abort_ff, abort_in;
   logic [31:0]               thresh_ff, thresh_in;

   logic [AW-1:0] raddr, waddr, clr_addr;
   logic          mem_we, clr_en, cfg_clear;
   logic [31:0]   wdata;
   logic [CW-1:0] cfg_n;

   logic [CW-1:0]             a_ext, last, room;
   logic [scce_pkg::PROD_W-1:0] prod;
   logic [scce_pkg::PROD_W:0]   grow_sum;
   logic [scce_pkg::PROD_W-8:0] grow_n;
   logic [CW-1:0]             grow_add;
   logic [AW-1:0]             j_next;
   logic                      issue;
   logic [32:0]               ci_x, cj_x, th_x, pair_sum;

   assign rd = rvalid_ff ? rdata_ff : 32'd0;

   always_comb begin
      a_ext    = {1'b0, cmd_ff.first_index};
      last     = count_ff - 1'b1;
      room     = CW'(scce_pkg::MAX_CHUNKS) - count_ff;
      prod     = count_ff * cmd_ff.grow_rate;
      grow_sum = {1'b0, prod} + (scce_pkg::PROD_W+1)'(384);
      grow_n   = grow_sum[scce_pkg::PROD_W:8];
      grow_add = (grow_n > (scce_pkg::PROD_W-7)'(room)) ? room : CW'(grow_n);
      j_next   = (a_ext + 1'b1 == count_ff) ? '0 : cmd_ff.first_index + 1'b1;
      issue    = (idx_ff < count_ff);
      ci_x     = {1'b0, tmp_ff};
      cj_x     = {1'b0, rd};
      th_x     = {1'b0, thresh_ff};
      pair_sum = ci_x + cj_x;
      cfg_n    = (csr_data[CW-1:0] == '0) ? CW'(1) :
                 (csr_data[CW-1:0] > CW'(scce_pkg::MAX_CHUNKS)) ?
                 CW'(scce_pkg::MAX_CHUNKS) : csr_data[CW-1:0];
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      pend_in    = pend_ff;
      left_in    = left_ff;
      tmp_in     = tmp_ff;
      j_in       = j_ff;
      outcome_in = outcome_ff;
      total_in   = total_ff;
      rc_in      = rc_ff;
      ra_in      = ra_ff;
      commit_in  = commit_ff;
      abort_in   = abort_ff;
      thresh_in  = thresh_ff;
      raddr      = '0;
      mem_we     = 1'b0;
      waddr      = '0;
      wdata      = '0;
      clr_en     = 1'b0;
      clr_addr   = '0;
      cfg_clear  = 1'b0;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;

      if (csr_we) begin
         if (csr_index == scce_pkg::CSR_INIT_CHUNKS) begin
            count_in  = cfg_n;
            cfg_clear = 1'b1;
         end else begin
            thresh_in = csr_data;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_in     = cmd;
               cmd_pop    = 1'b1;
               outcome_in = scce_pkg::OUT_DONE;
               total_in   = '0;
               rc_in      = '0;
               ra_in      = '0;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            idx_in   = '0;
            sum_in   = '0;
            pend_in  = 1'b0;
            if (cmd_ff.op_undefined) begin
               outcome_in = scce_pkg::OUT_REFUSED;
            end else begin
               unique case (cmd_ff.op)
                  scce_pkg::OP_READ: state_in = S_SUM;
                  scce_pkg::OP_ADD: begin
                     if (a_ext >= count_ff) begin
                        outcome_in = scce_pkg::OUT_RANGE;
                     end else begin
                        raddr    = cmd_ff.first_index;
                        state_in = S_ADD_WR;
                     end
                  end
                  scce_pkg::OP_SUB: begin
                     if (a_ext >= count_ff) begin
                        outcome_in = scce_pkg::OUT_RANGE;
                     end else begin
                        state_in = S_SUM;
                     end
                  end
                  scce_pkg::OP_GROW: begin
                     if (count_ff >= CW'(scce_pkg::MAX_CHUNKS)) begin
                        outcome_in = scce_pkg::OUT_REFUSED;
                     end else begin
                        count_in = count_ff + grow_add;
                     end
                  end
                  scce_pkg::OP_SHRINK: begin
                     if (count_ff < CW'(2)) begin
                        outcome_in = scce_pkg::OUT_REFUSED;
                     end else if (a_ext >= last) begin
                        outcome_in = scce_pkg::OUT_RANGE;
                     end else begin
                        raddr    = last[AW-1:0];
                        state_in = S_SHR_RD2;
                     end
                  end
                  scce_pkg::OP_BALANCE: begin
                     if (count_ff < CW'(2)) begin
                        outcome_in = scce_pkg::OUT_REFUSED;
                     end else if (a_ext >= count_ff) begin
                        outcome_in = scce_pkg::OUT_RANGE;
                     end else if (!cmd_ff.second_is_next &&
                                  {1'b0, cmd_ff.second_index} >= count_ff) begin
                        outcome_in = scce_pkg::OUT_RANGE;
                     end else begin
                        j_in     = cmd_ff.second_is_next ? j_next : cmd_ff.second_index;
                        raddr    = cmd_ff.first_index;
                        state_in = S_BAL_RD2;
                     end
                  end
                  scce_pkg::OP_FETCH: begin
                     rc_in     = commit_ff;
                     ra_in     = abort_ff;
                     commit_in = '0;
                     abort_in  = '0;
                  end
                  default: outcome_in = scce_pkg::OUT_REFUSED;
               endcase
            end
         end
         S_SUM: begin
            if (pend_ff) begin
               sum_in = sum_ff + scce_pkg::SUM_W'(rd);
            end
            if (issue) begin
               raddr   = idx_ff[AW-1:0];
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (!issue && !pend_ff) begin
               if (cmd_ff.op == scce_pkg::OP_READ) begin
                  total_in = sum_ff[31:0];
                  state_in = S_DONE;
               end else if (sum_ff < scce_pkg::SUM_W'(cmd_ff.amount)) begin
                  abort_in   = abort_ff + 1'b1;
                  outcome_in = scce_pkg::OUT_REFUSED;
                  state_in   = S_DONE;
               end else begin
                  left_in  = cmd_ff.amount;
                  idx_in   = a_ext;
                  state_in = S_WALK_RD;
               end
            end
         end
         S_WALK_RD: begin
            raddr    = idx_ff[AW-1:0];
            state_in = S_WALK_WR;
         end
         S_WALK_WR: begin
            mem_we = 1'b1;
            waddr  = idx_ff[AW-1:0];
            if (rd >= left_ff) begin
               wdata     = rd - left_ff;
               commit_in = commit_ff + 1'b1;
               state_in  = S_DONE;
            end else begin
               wdata    = '0;
               left_in  = left_ff - rd;
               idx_in   = (idx_ff + 1'b1 == count_ff) ? '0 : idx_ff + 1'b1;
               state_in = S_WALK_RD;
            end
         end
         S_ADD_WR: begin
            mem_we    = 1'b1;
            waddr     = cmd_ff.first_index;
            wdata     = rd + cmd_ff.amount;
            commit_in = commit_ff + 1'b1;
            state_in  = S_DONE;
         end
         S_SHR_RD2: begin
            tmp_in   = rd;
            raddr    = cmd_ff.first_index;
            state_in = S_SHR_WR;
         end
         S_SHR_WR: begin
            mem_we   = 1'b1;
            waddr    = cmd_ff.first_index;
            wdata    = rd + tmp_ff;
            clr_en   = 1'b1;
            clr_addr = last[AW-1:0];
            count_in = last;
            state_in = S_DONE;
         end
         S_BAL_RD2: begin
            tmp_in   = rd;
            raddr    = j_ff;
            state_in = S_BAL_WR1;
         end
         S_BAL_WR1: begin
            if (ci_x <= cj_x + th_x && cj_x <= ci_x + th_x) begin
               state_in = S_DONE;
            end else begin
               mem_we   = 1'b1;
               waddr    = cmd_ff.first_index;
               wdata    = pair_sum[32:1] + {31'd0, pair_sum[0]};
               tmp_in   = pair_sum[32:1];
               state_in = S_BAL_WR2;
            end
         end
         S_BAL_WR2: begin
            mem_we   = 1'b1;
            waddr    = j_ff;
            wdata    = tmp_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_push = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_data.total        = total_ff;
      rsp_data.outcome      = outcome_ff;
      rsp_data.active_count = count_ff;
      rsp_data.commits      = rc_ff;
      rsp_data.aborts       = ra_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= valid_ff[raddr];
         if (cfg_clear) begin
            for (int i = 0; i < scce_pkg::MAX_CHUNKS; i++) begin
               if ((CW+1)'(i) >= {1'b0, cfg_n}) begin
                  valid_ff[i] <= 1'b0;
               end
            end
         end
         if (mem_we) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (clr_en) begin
            valid_ff[clr_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= CW'(1);
         commit_ff <= '0;
         abort_ff  <= '0;
         thresh_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         commit_ff <= commit_in;
         abort_ff  <= abort_in;
         thresh_ff <= thresh_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
      pend_ff    <= pend_in;
      left_ff    <= left_in;
      tmp_ff     <= tmp_in;
      j_ff       <= j_in;
      outcome_ff <= outcome_in;
      total_ff   <= total_in;
      rc_ff      <= rc_in;
      ra_ff      <= ra_in;
   end

endmodule

/* hw/rtl/scce_checker.sv */
// Port-level checker for the split counter chunk engine, bound to the top level.
module scce_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic [31:0]                 rsp_total,
   input logic [1:0]                  rsp_outcome,
   input logic [scce_pkg::COUNT_W-1:0] rsp_active_count,
   input logic [15:0]                 rsp_commits,
   input logic [15:0]                 rsp_aborts
);

   // Reset leaves no stale response beat behind.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   // Only the three defined outcome codes ever appear.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_outcome == scce_pkg::OUT_DONE ||
                      rsp_outcome == scce_pkg::OUT_REFUSED ||
                      rsp_outcome == scce_pkg::OUT_RANGE))
      else $error("undefined outcome code");

   // The active chunk count stays within one and the maximum.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_active_count != '0 &&
                      rsp_active_count <= scce_pkg::COUNT_W'(scce_pkg::MAX_CHUNKS)))
      else $error("active chunk count out of range");

   // A response beat that is not popped holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_total) &&
                                    $stable(rsp_outcome) && $stable(rsp_active_count) &&
                                    $stable(rsp_commits) && $stable(rsp_aborts)))
      else $error("waiting response beat changed");

endmodule

bind split_counter_chunk_engine scce_checker u_scce_checker (.*);

/* tb/split_counter_chunk_engine_test.sv */
// Self-checking testbench of the split counter chunk engine with a scoreboard class.
`timescale 1ns / 100ps

module split_counter_chunk_engine_test;
   import scce_pkg::*;

   // Scoreboard: it keeps its own copy of the chunk array, the counters and the
   // settings, works out the response of every accepted request beat, and
   // checks each response beat against the oldest prediction.
   class chunk_scoreboard;
      logic [31:0] chunks [MAX_CHUNKS];
      int unsigned count;
      logic [15:0] commit_cnt, abort_cnt;
      logic [31:0] threshold;
      rsp_type     pending [$];
      int          errors;

      function new();
         errors = 0;
         threshold = 0;
         commit_cnt = 0;
         abort_cnt = 0;
         foreach (chunks[i]) chunks[i] = 0;
         count = 1;
      endfunction

      // Setting the chunk count clears every chunk that becomes inactive.
      function void resize(int unsigned n);
         for (int unsigned i = n; i < MAX_CHUNKS; i++) chunks[i] = 0;
         count = n;
      endfunction

      function void write_csr(logic idx, logic [31:0] data);
         int unsigned n;
         if (idx == CSR_INIT_CHUNKS) begin
            n = data[6:0];
            if (n < 1) n = 1;
            if (n > MAX_CHUNKS) n = MAX_CHUNKS;
            resize(n);
         end else begin
            threshold = data;
         end
      endfunction

      function longint unsigned chunk_total();
         longint unsigned s;
         s = 0;
         for (int unsigned i = 0; i < count; i++) s += chunks[i];
         return s;
      endfunction

      function void note_request(logic [2:0] op, logic [31:0] amount, logic [5:0] a,
                                 logic [5:0] b, logic [8:0] rate);
         rsp_type r;
         int unsigned idx, j, last;
         logic [31:0] left;
         longint unsigned n, ci, cj, s;
         r = '0;
         case (op)
            OP_READ: r.total = chunk_total();
            OP_ADD: begin
               if (a >= count) r.outcome = OUT_RANGE;
               else begin
                  chunks[a] += amount;
                  commit_cnt++;
               end
            end
            OP_SUB: begin
               if (a >= count) r.outcome = OUT_RANGE;
               else if (chunk_total() < amount) begin
                  abort_cnt++;
                  r.outcome = OUT_REFUSED;
               end else begin
                  idx = a;
                  left = amount;
                  for (int unsigned k = 0; k < count; k++) begin
                     if (chunks[idx] >= left) begin
                        chunks[idx] -= left;
                        break;
                     end
                     left -= chunks[idx];
                     chunks[idx] = 0;
                     idx = (idx + 1 == count) ? 0 : idx + 1;
                  end
                  commit_cnt++;
               end
            end
            OP_GROW: begin
               if (count >= MAX_CHUNKS) r.outcome = OUT_REFUSED;
               else begin
                  n = (256 + longint'(count) * rate + 128) >> 8;
                  if (n > MAX_CHUNKS - count) n = MAX_CHUNKS - count;
                  resize(count + int'(n));
               end
            end
            OP_SHRINK: begin
               if (count < 2) r.outcome = OUT_REFUSED;
               else begin
                  last = count - 1;
                  if (a >= last) r.outcome = OUT_RANGE;
                  else begin
                     chunks[a] += chunks[last];
                     resize(last);
                  end
               end
            end
            OP_BALANCE: begin
               j = b;
               if (count < 2) r.outcome = OUT_REFUSED;
               else if (a >= count) r.outcome = OUT_RANGE;
               else if (j != a && j >= count) r.outcome = OUT_RANGE;
               else begin
                  if (j == a) j = (a + 1 == count) ? 0 : a + 1;
                  ci = chunks[a];
                  cj = chunks[j];
                  if (!(ci <= cj + threshold && cj <= ci + threshold)) begin
                     s = ci + cj;
                     chunks[a] = (s >> 1) + (s & 1);
                     chunks[j] = s >> 1;
                  end
               end
            end
            OP_FETCH: begin
               r.commits = commit_cnt;
               r.aborts = abort_cnt;
               commit_cnt = 0;
               abort_cnt = 0;
            end
            default: r.outcome = OUT_REFUSED;
         endcase
         r.active_count = count;
         pending.push_back(r);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: response beat with nothing expected, got %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.total !== want.total) begin
            $display("%0t: total expected %h actual %h", $time, want.total, got.total);
            errors++;
         end
         if (got.outcome !== want.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, got.outcome);
            errors++;
         end
         if (got.active_count !== want.active_count) begin
            $display("%0t: active_count expected %0d actual %0d", $time,
                     want.active_count, got.active_count);
            errors++;
         end
         if (got.commits !== want.commits) begin
            $display("%0t: commits expected %0d actual %0d", $time, want.commits, got.commits);
            errors++;
         end
         if (got.aborts !== want.aborts) begin
            $display("%0t: aborts expected %0d actual %0d", $time, want.aborts, got.aborts);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_push = 0;
   logic                req_full;
   logic [2:0]          req_op = OP_READ;
   logic [31:0]         req_amount = 0;
   logic [ADDR_W-1:0]   req_first_index = 0;
   logic [ADDR_W-1:0]   req_second_index = 0;
   logic [RATE_W-1:0]   req_grow_rate = 0;
   logic                rsp_empty;
   logic                rsp_pop = 0;
   logic [31:0]         rsp_total;
   logic [1:0]          rsp_outcome;
   logic [COUNT_W-1:0]  rsp_active_count;
   logic [15:0]         rsp_commits;
   logic [15:0]         rsp_aborts;
   logic                csr_we = 0;
   logic                csr_index = CSR_INIT_CHUNKS;
   logic [31:0]         csr_data = 0;

   split_counter_chunk_engine uut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   chunk_scoreboard board = new();

   // Idle and stall percentages of each side; the stimulus process sets them
   // per phase. The long hold-off flag freezes the receiver completely.
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 0;
   bit  stimulus_done = 0;
   int  quiet_cycles = 0;
   localparam int WATCHDOG_LIMIT = 20000;

   // Receiver: pop is decided each rising edge for the next cycle, and every
   // beat taken at an edge (pop high, empty low) goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            board.check_response('{rsp_total, rsp_outcome, rsp_active_count,
                                   rsp_commits, rsp_aborts});
         rsp_pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: counts cycles in which no beat moves on either side. The
   // limit leaves a wide margin over the longest correct gap, a full sub walk
   // behind a long receiver hold-off.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("split_counter_chunk_engine_test: errors");
         $finish;
      end
   end

   // Offers one request beat and waits until the block takes it. Idle gaps
   // are inserted in front of the beat as the current phase asks.
   task automatic send_beat(logic [2:0] op, logic [31:0] amount, logic [5:0] a,
                            logic [5:0] b, logic [8:0] rate);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(posedge clock);
      end
      req_push <= 1;
      req_op <= op;
      req_amount <= amount;
      req_first_index <= a;
      req_second_index <= b;
      req_grow_rate <= rate;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(op, amount, a, b, rate);
   endtask

   // Lowers push and waits until every predicted response has been taken,
   // then lets the sequencer settle before any register write.
   task automatic drain();
      req_push <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [31:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_we <= 0;
      board.write_csr(idx, data);
      @(posedge clock);
   endtask

   // Random amounts lean toward small values so that sub both succeeds and
   // falls short, with some full-range values for wrapping.
   function automatic logic [31:0] pick_amount();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1000);
         2: return 32'hFFFF_FFFF - $urandom_range(3);
         default: return $urandom_range(100000);
      endcase
   endfunction

   // A random request: indexes mostly inside the active range, sometimes
   // anywhere, and grow and shrink drawn like the other ops so that the count varies.
   task automatic random_beat();
      logic [2:0] op;
      int unsigned lim;
      logic [5:0] a, b;
      op = $urandom_range(7);
      if ($urandom_range(9) == 0) op = 3'd7;
      else if (op == 3'd7) op = OP_ADD;
      lim = (board.count > 0) ? board.count - 1 : 0;
      a = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(lim));
      b = ($urandom_range(3) == 0) ? a :
          ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(lim));
      send_beat(op, pick_amount(), a, b, 9'($urandom_range(511)));
   endtask

   initial begin
      int pct [4] = '{0, 48, 0, 31};
      int rpct [4] = '{0, 0, 48, 31};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: reset state, extremes of every field and each corner.
      send_beat(OP_READ, 0, 0, 0, 0);
      send_beat(OP_SHRINK, 0, 0, 0, 0);                // one chunk: refused
      send_beat(OP_BALANCE, 0, 0, 0, 0);               // one chunk: refused
      send_beat(OP_ADD, 32'hFFFF_FFFF, 0, 0, 0);
      send_beat(OP_ADD, 2, 0, 0, 0);                   // wraps
      send_beat(OP_ADD, 5, 63, 63, 0);                 // out of range
      send_beat(OP_SUB, 2, 0, 0, 0);                   // short
      send_beat(OP_SUB, 1, 0, 0, 0);                   // total equals amount
      send_beat(OP_SUB, 0, 0, 0, 0);
      send_beat(OP_GROW, 0, 0, 0, 9'd511);
      send_beat(OP_ADD, 32'hFFFF_FFFF, 1, 0, 0);
      send_beat(OP_ADD, 32'hFFFF_FFFF, 2, 0, 0);
      send_beat(OP_READ, 0, 0, 0, 0);                  // sum wraps
      send_beat(OP_SUB, 32'hFFFF_FFFF, 2, 0, 0);       // taken from chunk 2 alone
      send_beat(OP_BALANCE, 0, 1, 1, 0);               // second equal to first
      send_beat(OP_BALANCE, 0, 0, 63, 0);              // second out of range
      send_beat(OP_SHRINK, 0, 0, 0, 0);
      send_beat(OP_SHRINK, 0, 63, 0, 0);
      send_beat(OP_GROW, 0, 0, 0, 9'd256);
      send_beat(3'd7, 32'hFFFF_FFFF, 63, 63, 9'h1FF);  // undefined op
      send_beat(OP_FETCH, 0, 0, 0, 0);
      send_beat(OP_FETCH, 0, 0, 0, 0);
      drain();
      write_register(CSR_INIT_CHUNKS, 32'd127);        // clamps to the maximum
      write_register(CSR_THRESHOLD, 32'hFFFF_FFFF);
      send_beat(OP_GROW, 0, 0, 0, 0);                  // full: refused
      send_beat(OP_ADD, 1000, 63, 0, 0);
      send_beat(OP_BALANCE, 0, 63, 0, 0);              // under threshold
      send_beat(OP_READ, 0, 0, 0, 0);
      drain();
      write_register(CSR_INIT_CHUNKS, 32'd0);          // taken as one
      write_register(CSR_THRESHOLD, 32'd0);
      send_beat(OP_READ, 0, 0, 0, 0);

      // Random part in phases with different settings and idling patterns.
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         write_register(CSR_INIT_CHUNKS, (phase % 3 == 0) ? 64 : $urandom_range(1, 64));
         write_register(CSR_THRESHOLD, (phase % 4 == 1) ? 0 :
                        (phase % 4 == 2) ? 32'hFFFF_FFFF : $urandom_range(5000));
         send_idle_pct = pct[phase % 4];
         recv_stall_pct = rpct[phase % 4];
         for (int i = 0; i < 232; i++) random_beat();
         if (phase == 2) begin
            // Receiver holds off for a long stretch while requests keep coming.
            fork
               begin
                  hold_off = 1;
                  repeat (400) @(posedge clock);
                  hold_off = 0;
               end
               for (int i = 0; i < 12; i++) random_beat();
            join
         end
         if (phase == 5) begin
            // Sender pauses until every expected response has arrived.
            req_push <= 0;
            @(posedge clock);
            while (board.pending.size() != 0) @(posedge clock);
         end
      end

      req_push <= 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      stimulus_done = 1;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("split_counter_chunk_engine_test: clean");
      else
         $display("split_counter_chunk_engine_test: errors");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/scce_pkg.sv
hw/rtl/scce_front.sv
hw/rtl/scce_rsp_queue.sv
hw/rtl/scce_back.sv
hw/rtl/split_counter_chunk_engine.sv
hw/rtl/scce_checker.sv
tb/split_counter_chunk_engine_test.sv
